[hw/rtl/brk4_pkg.sv]
// ----------------------------------------------------------------------------
// brk4_pkg
// Widths, store indexes and helper functions for the body rate RK4 stepper.
// ----------------------------------------------------------------------------
package brk4_pkg;

  localparam int DW      = 32;   // rate, torque, momentum, inertia words
  localparam int OPW     = 33;   // multiplier operand, signed
  localparam int PW      = 2 * OPW;
  localparam int ACC_W   = 98;   // holds the full determinant
  localparam int REM_W   = 98;   // divider remainder and divisor
  localparam int NUM_W   = 104;  // |adj| * 2^40
  localparam int SUM_W   = 48;   // RK4 weighted sum
  localparam int ADJ_W   = 64;
  localparam int NREG    = 6;
  localparam int AXES    = 3;
  localparam int IDX_W   = 3;
  localparam int INV_FRAC      = 40;
  localparam int INV_DIV_STEPS = 104;
  localparam int FIN_DIGIT     = 8;    // sum bits retired per divide-by-6 step
  localparam int FIN_DIV_STEPS = SUM_W / FIN_DIGIT;
  localparam int FIN_DIVISOR   = 6;
  localparam int FIN_V_W       = FIN_DIGIT + 3;  // remainder below 6 plus one digit
  localparam int FIN_P_W       = FIN_V_W + 10;
  localparam int FIN_RECIP     = 683;  // 2^12 / 6 rounded up, exact for v < 2^11
  localparam int FIN_RECIP_SH  = 12;
  localparam int DCNT_W  = $clog2(INV_DIV_STEPS + 1);

  typedef logic [IDX_W-1:0] ent_t;

  // symmetric store order, shared by config, adjugate and inverse
  localparam ent_t E_XX = 3'd0;
  localparam ent_t E_YY = 3'd1;
  localparam ent_t E_ZZ = 3'd2;
  localparam ent_t E_XY = 3'd3;
  localparam ent_t E_XZ = 3'd4;
  localparam ent_t E_YZ = 3'd5;

  localparam logic signed [DW-1:0] SAT_MAX = 32'sh7FFF_FFFF;

  localparam logic signed [DW-1:0] RATE_RST_X = 32'sd838861;
  localparam logic signed [DW-1:0] RATE_RST_Y = -32'sd671089;
  localparam logic signed [DW-1:0] RATE_RST_Z = 32'sd1677722;

  localparam logic signed [DW-1:0] J_RST_XX = 32'sd655360;
  localparam logic signed [DW-1:0] J_RST_YY = 32'sd1310720;
  localparam logic signed [DW-1:0] J_RST_ZZ = 32'sd1966080;

  // entry of the symmetric matrix at row r, column c
  function automatic ent_t sym_ent(input logic [1:0] r, input logic [1:0] c);
    ent_t e;
    unique case ({r, c})
      4'b0000: e = E_XX;
      4'b0001: e = E_XY;
      4'b0010: e = E_XZ;
      4'b0100: e = E_XY;
      4'b0101: e = E_YY;
      4'b0110: e = E_YZ;
      4'b1000: e = E_XZ;
      4'b1001: e = E_YZ;
      4'b1010: e = E_ZZ;
      default: e = E_XX;
    endcase
    return e;
  endfunction

  // operand pair {a, b} of the first or second product of adjugate entry e
  function automatic logic [2*IDX_W-1:0] adj_pair(input ent_t e, input logic second);
    logic [2*IDX_W-1:0] p;
    unique case ({e, second})
      {E_XX, 1'b0}: p = {E_YY, E_ZZ};
      {E_XX, 1'b1}: p = {E_YZ, E_YZ};
      {E_YY, 1'b0}: p = {E_XX, E_ZZ};
      {E_YY, 1'b1}: p = {E_XZ, E_XZ};
      {E_ZZ, 1'b0}: p = {E_XX, E_YY};
      {E_ZZ, 1'b1}: p = {E_XY, E_XY};
      {E_XY, 1'b0}: p = {E_XZ, E_YZ};
      {E_XY, 1'b1}: p = {E_XY, E_ZZ};
      {E_XZ, 1'b0}: p = {E_XY, E_YZ};
      {E_XZ, 1'b1}: p = {E_XZ, E_YY};
      {E_YZ, 1'b0}: p = {E_XY, E_XZ};
      {E_YZ, 1'b1}: p = {E_XX, E_YZ};
      default:      p = {E_XX, E_XX};
    endcase
    return p;
  endfunction

  // first-row entries used for the determinant expansion
  function automatic ent_t det_ent(input logic [1:0] t);
    ent_t e;
    unique case (t)
      2'd0:    e = E_XX;
      2'd1:    e = E_XY;
      2'd2:    e = E_XZ;
      default: e = E_XX;
    endcase
    return e;
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] x);
    return (x == 2'd0) ? 2'd2 : x - 2'd1;
  endfunction

  // symmetric clip to 32 bits: {clipped, value}
  function automatic logic [DW:0] sat32(input logic signed [ACC_W-1:0] x);
    logic [DW:0] r;
    if (x > ACC_W'(SAT_MAX)) begin
      r = {1'b1, SAT_MAX};
    end else if (x < -ACC_W'(SAT_MAX)) begin
      r = {1'b1, -SAT_MAX};
    end else begin
      r = {1'b0, x[DW-1:0]};
    end
    return r;
  endfunction

endpackage

[hw/rtl/body_rate_rk4_step_top.sv]
// ----------------------------------------------------------------------------
// body_rate_rk4_step_top
// One RK4 step of Euler's rigid-body equations with wheel momentum. Every
// request returns one result. A load request (cmd 1) replaces the body rate
// and goes straight to the result. An integrate request runs 108 multiply
// steps (fetch, multiply, accumulate) on the one shared 33x33 multiplier
// (four derivative passes of 27 products), then three divisions by 6 for the
// weighted sum, each taking a byte of the sum per cycle through a reciprocal
// multiply. The first integrate request after reset or after a write to an
// inertia register (index 0 to 5) also builds the inverse inertia first (18
// products, then six 104-step shift-subtract divisions); a singular inertia
// ends the request there. The block takes one request at a time; a finished
// result waits in the output register while the next request is accepted.
// Register writes are taken at any time and should come while idle.
// ----------------------------------------------------------------------------
module body_rate_rk4_step_top
  import brk4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [DW-1:0]        cfg_data,

  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 cmd,
  input  logic [DW-1:0]        step_len,
  input  logic signed [DW-1:0] wheel_mom_x,
  input  logic signed [DW-1:0] wheel_mom_y,
  input  logic signed [DW-1:0] wheel_mom_z,
  input  logic signed [DW-1:0] torque_x,
  input  logic signed [DW-1:0] torque_y,
  input  logic signed [DW-1:0] torque_z,
  input  logic signed [DW-1:0] load_rate_x,
  input  logic signed [DW-1:0] load_rate_y,
  input  logic signed [DW-1:0] load_rate_z,

  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [DW-1:0] rate_x,
  output logic signed [DW-1:0] rate_y,
  output logic signed [DW-1:0] rate_z,
  output logic                 saturated,
  output logic                 singular
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DCHK, ST_ILOAD, ST_IDIV, ST_IWR,
    ST_FLOAD, ST_FDIV, ST_FWR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {PH_ADJ, PH_DET, PH_L, PH_X, PH_K, PH_T} phase_t;

  typedef enum logic [1:0] {CY_FETCH, CY_MUL, CY_ACC} cyc_t;

  state_t state;
  phase_t phase;
  cyc_t   cyc;

  logic [IDX_W-1:0] ci;
  logic [1:0]       cj;
  logic [1:0]       rnd;
  logic [IDX_W-1:0] de;
  logic [DCNT_W-1:0] dcnt;

  logic signed [DW-1:0]    cfg_reg [NREG];
  logic signed [ADJ_W-1:0] adj     [NREG];
  logic signed [DW-1:0]    inv     [NREG];
  logic signed [DW-1:0]    rate    [AXES];
  logic signed [DW-1:0]    srate   [AXES];
  logic signed [DW-1:0]    lvec    [AXES];
  logic signed [DW-1:0]    mvec    [AXES];
  logic signed [DW-1:0]    kvec    [AXES];
  logic signed [SUM_W-1:0] ssum    [AXES];
  logic signed [DW-1:0]    hmom    [AXES];
  logic signed [DW-1:0]    tq      [AXES];
  logic [DW-1:0]           dt;

  logic signed [OPW-1:0]   opa;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;
  logic [REM_W-1:0]        dvsr;
  logic [REM_W-1:0]        rem;
  logic [NUM_W-1:0]        num;
  logic                    dneg;
  logic                    clip;
  logic                    sing;
  logic                    inv_ready;

  // operand addressing
  ent_t       cfg_addr, adj_addr, inv_addr;
  logic [1:0] s_addr, l_addr, m_addr, k_addr;
  logic [2*IDX_W-1:0] adjp;
  logic signed [DW-1:0]    cfg_rd, inv_rd, s_rd, l_rd, m_rd, k_rd;
  logic signed [ADJ_W-1:0] adj_rd;
  logic signed [OPW-1:0]   amux, bmux;

  assign adjp     = adj_pair(ci, cj[0]);
  assign adj_addr = det_ent(ci[1:0]);
  assign inv_addr = sym_ent(ci[1:0], cj);
  assign s_addr   = (phase == PH_X) ? ((cj == 2'd0) ? inc3(ci[1:0]) : dec3(ci[1:0])) : cj;
  assign l_addr   = (cj == 2'd0) ? dec3(ci[1:0]) : inc3(ci[1:0]);
  assign m_addr   = cj;
  assign k_addr   = ci[1:0];

  always_comb begin
    unique case (phase)
      PH_ADJ:  cfg_addr = (cyc == CY_FETCH) ? adjp[2*IDX_W-1:IDX_W] : adjp[IDX_W-1:0];
      PH_DET:  cfg_addr = det_ent(ci[1:0]);
      PH_L:    cfg_addr = sym_ent(ci[1:0], cj);
      default: cfg_addr = E_XX;
    endcase
  end

  assign cfg_rd = cfg_reg[cfg_addr];
  assign inv_rd = inv[inv_addr];
  assign adj_rd = adj[adj_addr];
  assign s_rd   = srate[s_addr];
  assign l_rd   = lvec[l_addr];
  assign m_rd   = mvec[m_addr];
  assign k_rd   = kvec[k_addr];

  always_comb begin
    unique case (phase)
      PH_ADJ, PH_DET, PH_L: amux = OPW'(cfg_rd);
      PH_X:    amux = OPW'(s_rd);
      PH_K:    amux = OPW'(inv_rd);
      PH_T:    amux = OPW'(k_rd);
      default: amux = '0;
    endcase
  end

  always_comb begin
    unique case (phase)
      PH_ADJ:  bmux = OPW'(cfg_rd);
      PH_DET:  bmux = (cj == 2'd0) ? OPW'(signed'(adj_rd[ADJ_W-1:DW]))
                                   : signed'({1'b0, adj_rd[DW-1:0]});
      PH_L:    bmux = OPW'(s_rd);
      PH_X:    bmux = OPW'(l_rd);
      PH_K:    bmux = OPW'(m_rd);
      PH_T:    bmux = signed'({1'b0, dt});
      default: bmux = '0;
    endcase
  end

  // accumulate step
  logic signed [ACC_W-1:0] pe, term, base, acc_new, stg_sum, fin_sum, sat_in;
  logic signed [SUM_W-1:0] p20, ssum_new, fq;
  logic [SUM_W-1:0]        fq_mag, ssum_abs;
  logic [DW:0]             sat_out;
  logic                    last_j, last_i;

  assign pe = ACC_W'(prod);

  always_comb begin
    term = pe;
    base = '0;
    unique case (phase)
      PH_ADJ: begin
        term = cj[0] ? -pe : pe;
        base = cj[0] ? acc : '0;
      end
      PH_DET: begin
        term = (cj == 2'd0) ? (pe <<< DW) : pe;
        base = (ci == '0 && cj == 2'd0) ? '0 : acc;
      end
      PH_L: begin
        term = pe >>> 24;
        base = (cj == 2'd0) ? ACC_W'(hmom[ci[1:0]]) : acc;
      end
      PH_X: begin
        term = (cj == 2'd0) ? -(pe >>> 24) : (pe >>> 24);
        base = (cj == 2'd0) ? ACC_W'(tq[ci[1:0]]) : acc;
      end
      PH_K: begin
        term = pe >>> 16;
        base = (cj == 2'd0) ? '0 : acc;
      end
      default: begin
        term = pe;
        base = '0;
      end
    endcase
  end

  assign acc_new  = base + term;
  assign stg_sum  = ACC_W'(rate[ci[1:0]]) + ((rnd == 2'd2) ? (pe >>> 28) : (pe >>> 29));
  assign p20      = SUM_W'(pe >>> 20);
  assign ssum_new = ((rnd == 2'd0) ? SUM_W'(0) : ssum[ci[1:0]])
                  + ((rnd == 2'd1 || rnd == 2'd2) ? (p20 <<< 1) : p20);

  // sum / 6 truncates toward zero: divide the magnitude, then restore sign
  assign ssum_abs = ssum[de[1:0]][SUM_W-1] ? SUM_W'(-ssum[de[1:0]]) : SUM_W'(ssum[de[1:0]]);
  assign fq_mag   = num[SUM_W-1:0];
  assign fq       = ssum[de[1:0]][SUM_W-1] ? -signed'(fq_mag) : signed'(fq_mag);
  assign fin_sum  = ACC_W'(rate[de[1:0]]) + ACC_W'(fq >>> 8);

  assign sat_in  = (state == ST_FWR) ? fin_sum : ((phase == PH_T) ? stg_sum : acc_new);
  assign sat_out = sat32(sat_in);

  always_comb begin
    unique case (phase)
      PH_ADJ, PH_DET, PH_X: last_j = (cj == 2'd1);
      PH_T:    last_j = 1'b1;
      default: last_j = (cj == 2'd2);
    endcase
  end
  assign last_i = (phase == PH_ADJ) ? (ci == E_YZ) : (ci == IDX_W'(AXES - 1));

  // shift-subtract divider for the inverse entries
  logic [REM_W-1:0] rem_sh, rem_nx;
  logic             div_ge;
  assign rem_sh = {rem[REM_W-2:0], num[NUM_W-1]};
  assign div_ge = (rem_sh >= dvsr);
  assign rem_nx = div_ge ? (rem_sh - dvsr) : rem_sh;

  // divide by 6 a byte at a time: running remainder (below 6) joined with
  // the next byte stays under 2^11, where the reciprocal multiply is exact
  logic [FIN_V_W-1:0] fv, frem;
  logic [FIN_P_W-1:0] fprod;
  logic [FIN_DIGIT-1:0] fq8;
  assign fv    = {rem[2:0], num[NUM_W-1 -: FIN_DIGIT]};
  assign fprod = {10'b0, fv} * FIN_P_W'(FIN_RECIP);
  assign fq8   = fprod[FIN_RECIP_SH +: FIN_DIGIT];
  assign frem  = fv - ({3'b0, fq8} * FIN_V_W'(FIN_DIVISOR));

  logic [ADJ_W-1:0]        adj_mag;
  logic [REM_W-1:0]        det_mag;
  logic                    inv_big, inv_neg;
  logic [DW-2:0]           inv_q;
  logic signed [DW-1:0]    inv_val;
  assign adj_mag = adj[de][ADJ_W-1] ? ADJ_W'(-adj[de]) : ADJ_W'(adj[de]);
  assign det_mag = acc[ACC_W-1] ? REM_W'(-acc) : REM_W'(acc);
  assign inv_big = |num[NUM_W-1:DW-1];
  assign inv_q   = inv_big ? SAT_MAX[DW-2:0] : num[DW-2:0];
  assign inv_neg = adj[de][ADJ_W-1] ^ dneg;
  assign inv_val = inv_neg ? -signed'({1'b0, inv_q}) : signed'({1'b0, inv_q});

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_ADJ;
      cyc          <= CY_FETCH;
      ci           <= '0;
      cj           <= '0;
      rnd          <= '0;
      de           <= '0;
      dcnt         <= '0;
      clip         <= 1'b0;
      sing         <= 1'b0;
      inv_ready    <= 1'b0;
      result_valid <= 1'b0;
      rate[0]      <= RATE_RST_X;
      rate[1]      <= RATE_RST_Y;
      rate[2]      <= RATE_RST_Z;
      cfg_reg[E_XX] <= J_RST_XX;
      cfg_reg[E_YY] <= J_RST_YY;
      cfg_reg[E_ZZ] <= J_RST_ZZ;
      cfg_reg[E_XY] <= '0;
      cfg_reg[E_XZ] <= '0;
      cfg_reg[E_YZ] <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            dt      <= step_len;
            hmom[0] <= wheel_mom_x;
            hmom[1] <= wheel_mom_y;
            hmom[2] <= wheel_mom_z;
            tq[0]   <= torque_x;
            tq[1]   <= torque_y;
            tq[2]   <= torque_z;
            for (int a = 0; a < AXES; a++) begin
              srate[a] <= rate[a];
            end
            clip  <= 1'b0;
            sing  <= 1'b0;
            ci    <= '0;
            cj    <= '0;
            rnd   <= '0;
            cyc   <= CY_FETCH;
            phase <= inv_ready ? PH_L : PH_ADJ;
            if (cmd) begin
              rate[0] <= load_rate_x;
              rate[1] <= load_rate_y;
              rate[2] <= load_rate_z;
              state   <= ST_DONE;
            end else begin
              state <= ST_MAC;
            end
          end
        end

        ST_MAC: begin
          unique case (cyc)
            CY_FETCH: begin
              opa <= amux;
              cyc <= CY_MUL;
            end
            CY_MUL: begin
              prod <= opa * bmux;
              cyc  <= CY_ACC;
            end
            CY_ACC: begin
              cyc <= CY_FETCH;
              acc <= acc_new;
              unique case (phase)
                PH_ADJ: if (cj[0]) adj[ci] <= acc_new[ADJ_W-1:0];
                PH_L: if (cj == 2'd2) begin
                  lvec[ci[1:0]] <= sat_out[DW-1:0];
                  clip <= clip | sat_out[DW];
                end
                PH_X: if (cj == 2'd1) begin
                  mvec[ci[1:0]] <= sat_out[DW-1:0];
                  clip <= clip | sat_out[DW];
                end
                PH_K: if (cj == 2'd2) begin
                  kvec[ci[1:0]] <= sat_out[DW-1:0];
                  clip <= clip | sat_out[DW];
                end
                PH_T: begin
                  ssum[ci[1:0]] <= ssum_new;
                  if (rnd != 2'd3) begin
                    srate[ci[1:0]] <= sat_out[DW-1:0];
                    clip <= clip | sat_out[DW];
                  end
                end
                default: ;
              endcase
              if (last_j) begin
                cj <= '0;
                if (last_i) begin
                  ci <= '0;
                  unique case (phase)
                    PH_ADJ: phase <= PH_DET;
                    PH_DET: state <= ST_DCHK;
                    PH_L:   phase <= PH_X;
                    PH_X:   phase <= PH_K;
                    PH_K:   phase <= PH_T;
                    PH_T: begin
                      if (rnd == 2'd3) begin
                        de    <= '0;
                        state <= ST_FLOAD;
                      end else begin
                        rnd   <= rnd + 2'd1;
                        phase <= PH_L;
                      end
                    end
                    default: phase <= PH_ADJ;
                  endcase
                end else begin
                  ci <= ci + 1'b1;
                end
              end else begin
                cj <= cj + 2'd1;
              end
            end
            default: cyc <= CY_FETCH;
          endcase
        end

        ST_DCHK: begin
          if (acc == '0) begin
            sing  <= 1'b1;
            clip  <= 1'b0;
            state <= ST_DONE;
          end else begin
            dvsr  <= det_mag;
            dneg  <= acc[ACC_W-1];
            de    <= '0;
            state <= ST_ILOAD;
          end
        end

        ST_ILOAD: begin
          num   <= {adj_mag, INV_FRAC'(0)};
          rem   <= '0;
          dcnt  <= DCNT_W'(INV_DIV_STEPS);
          state <= ST_IDIV;
        end

        ST_IDIV: begin
          num  <= {num[NUM_W-2:0], div_ge};
          rem  <= rem_nx;
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCNT_W'(1)) begin
            state <= ST_IWR;
          end
        end

        ST_IWR: begin
          inv[de] <= inv_val;
          clip    <= clip | inv_big;
          if (de == E_YZ) begin
            inv_ready <= 1'b1;
            phase     <= PH_L;
            ci        <= '0;
            cj        <= '0;
            rnd       <= '0;
            cyc       <= CY_FETCH;
            state     <= ST_MAC;
          end else begin
            de    <= de + 1'b1;
            state <= ST_ILOAD;
          end
        end

        ST_FLOAD: begin
          num   <= {ssum_abs, (NUM_W - SUM_W)'(0)};
          rem   <= '0;
          dcnt  <= DCNT_W'(FIN_DIV_STEPS);
          state <= ST_FDIV;
        end

        ST_FDIV: begin
          num  <= {num[NUM_W-FIN_DIGIT-1:0], fq8};
          rem  <= REM_W'(frem[2:0]);
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCNT_W'(1)) begin
            state <= ST_FWR;
          end
        end

        ST_FWR: begin
          rate[de[1:0]] <= sat_out[DW-1:0];
          clip          <= clip | sat_out[DW];
          if (de == IDX_W'(AXES - 1)) begin
            state <= ST_DONE;
          end else begin
            de    <= de + 1'b1;
            state <= ST_FLOAD;
          end
        end

        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            rate_x       <= rate[0];
            rate_y       <= rate[1];
            rate_z       <= rate[2];
            saturated    <= clip;
            singular     <= sing;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase

      // a write to an inertia register (index 0 to 5) drops the cached inverse
      if (cfg_valid && cfg_ready && cfg_index <= IDX_W'(NREG - 1)) begin
        if (cfg_index < E_XY) begin
          cfg_reg[cfg_index] <= signed'({1'b0, cfg_data[DW-2:0]});
        end else begin
          cfg_reg[cfg_index] <= cfg_data;
        end
        inv_ready <= 1'b0;
      end
    end
  end

  a_sing_not_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(singular && saturated))
    else $error("singular result flagged saturated");

  a_load_short: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && cmd) |=> (state == ST_DONE))
    else $error("load request did not go straight to result");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDIV) |-> (rem < dvsr))
    else $error("divider remainder not below divisor");

  a_fin_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FDIV) |-> (rem < REM_W'(FIN_DIVISOR)))
    else $error("divide-by-6 remainder out of range");

  a_inv_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(inv_ready) |-> ($past(state) == ST_IWR))
    else $error("inverse marked ready outside inverse write");

endmodule

[verif/tb_body_rate_rk4_step_top.sv]
// ----------------------------------------------------------------------------
// tb_body_rate_rk4_step_top
// Self-checking bench for the body rate RK4 stepper. A queue-fed driver sends
// load and integrate requests under random idling, a monitor checks every
// result against a bit-accurate predictor, and inertia settings are rewritten
// between batches while the block is idle.
// ----------------------------------------------------------------------------
module tb_body_rate_rk4_step_top;
  import brk4_pkg::*;

  localparam int      CYCLE_LIMIT = 4000000;
  localparam int      SET_ITEMS   = 108;
  localparam bit      CMD_STEP    = 1'b0;
  localparam bit      CMD_LOAD    = 1'b1;
  localparam ent_t    IDX_UNUSED  = 3'd7;
  localparam longint  RMAX        = 64'sd2147483647;
  localparam int      SYM[3][3]   = '{'{0, 3, 4}, '{3, 1, 5}, '{4, 5, 2}};

  typedef struct {
    bit          cmd;
    bit [31:0]   step;
    int          mom[3];
    int          trq[3];
    int          ld[3];
  } rate_req_t;

  typedef struct {
    int rate[3];
    bit sat;
    bit sing;
  } rate_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DW-1:0]     cfg_data  = '0;

  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              cmd = 1'b0;
  logic [DW-1:0]     step_len = '0;
  logic signed [DW-1:0] wheel_mom_x = '0, wheel_mom_y = '0, wheel_mom_z = '0;
  logic signed [DW-1:0] torque_x = '0, torque_y = '0, torque_z = '0;
  logic signed [DW-1:0] load_rate_x = '0, load_rate_y = '0, load_rate_z = '0;

  logic              result_valid;
  logic              result_stall = 1'b0;
  logic signed [DW-1:0] rate_x, rate_y, rate_z;
  logic              saturated, singular;

  body_rate_rk4_step_top DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  longint jmat[6];
  int     inv_j[6];
  bit     inv_ready;
  int     body_w[3];
  int     mom_cur[3], trq_cur[3];
  bit     clipped;

  rate_req_t req_q[$];
  rate_res_t rate_expect[$];
  rate_req_t cur_req;
  int        send_idle_pct, recv_stall_pct;
  int        errors = 0;
  int        cycles = 0;

  function automatic int clip32(input longint x);
    if (x > RMAX) begin
      clipped = 1'b1;
      return int'(RMAX);
    end
    if (x < -RMAX) begin
      clipped = 1'b1;
      return int'(-RMAX);
    end
    return int'(x);
  endfunction

  // adjugate over determinant; returns 0 for a singular inertia
  function automatic bit build_inverse();
    logic signed [127:0] adj[6];
    logic signed [127:0] xx, yy, zz, xy, xz, yz, det;
    logic [127:0] dmag, mag, q;
    int v;
    xx = jmat[0]; yy = jmat[1]; zz = jmat[2];
    xy = jmat[3]; xz = jmat[4]; yz = jmat[5];
    adj[0] = yy * zz - yz * yz;
    adj[1] = xx * zz - xz * xz;
    adj[2] = xx * yy - xy * xy;
    adj[3] = xz * yz - xy * zz;
    adj[4] = xy * yz - xz * yy;
    adj[5] = xy * xz - xx * yz;
    det = xx * adj[0] + xy * adj[3] + xz * adj[4];
    if (det == 0) return 1'b0;
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 6; i++) begin
      mag = (adj[i] < 0) ? -adj[i] : adj[i];
      q = (mag << 40) / dmag;
      if (q > 128'h7FFF_FFFF) begin
        clipped = 1'b1;
        q = 128'h7FFF_FFFF;
      end
      v = int'(q[31:0]);
      inv_j[i] = ((adj[i] < 0) != (det < 0)) ? -v : v;
    end
    return 1'b1;
  endfunction

  function automatic void rate_deriv(input int w[3], output int k[3]);
    longint s;
    longint c[3];
    int l[3], m[3];
    for (int i = 0; i < 3; i++) begin
      s = mom_cur[i];
      for (int j = 0; j < 3; j++) s += (jmat[SYM[i][j]] * longint'(w[j])) >>> 24;
      l[i] = clip32(s);
    end
    c[0] = ((longint'(w[1]) * l[2]) >>> 24) - ((longint'(w[2]) * l[1]) >>> 24);
    c[1] = ((longint'(w[2]) * l[0]) >>> 24) - ((longint'(w[0]) * l[2]) >>> 24);
    c[2] = ((longint'(w[0]) * l[1]) >>> 24) - ((longint'(w[1]) * l[0]) >>> 24);
    for (int i = 0; i < 3; i++) m[i] = clip32(longint'(trq_cur[i]) - c[i]);
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += (longint'(inv_j[SYM[i][j]]) * m[j]) >>> 16;
      k[i] = clip32(s);
    end
  endfunction

  function automatic void stage_rate(input int k[3], input longint dt, input int sh,
                                     output int o[3]);
    for (int i = 0; i < 3; i++)
      o[i] = clip32(longint'(body_w[i]) + ((longint'(k[i]) * dt) >>> sh));
  endfunction

  function automatic rate_res_t advance_rate(input rate_req_t r);
    rate_res_t res;
    int k1[3], k2[3], k3[3], k4[3], s[3];
    longint dt, sum;
    bit sing;
    sing = 1'b0;
    clipped = 1'b0;
    if (r.cmd == CMD_LOAD) begin
      body_w = r.ld;
    end else begin
      mom_cur = r.mom;
      trq_cur = r.trq;
      if (!inv_ready) begin
        if (build_inverse()) inv_ready = 1'b1;
        else sing = 1'b1;
      end
      if (sing) begin
        clipped = 1'b0;
      end else begin
        dt = longint'({32'b0, r.step});
        rate_deriv(body_w, k1);
        stage_rate(k1, dt, 29, s);
        rate_deriv(s, k2);
        stage_rate(k2, dt, 29, s);
        rate_deriv(s, k3);
        stage_rate(k3, dt, 28, s);
        rate_deriv(s, k4);
        for (int i = 0; i < 3; i++) begin
          sum = ((longint'(k1[i]) * dt) >>> 20) + 2 * ((longint'(k2[i]) * dt) >>> 20)
              + 2 * ((longint'(k3[i]) * dt) >>> 20) + ((longint'(k4[i]) * dt) >>> 20);
          s[i] = clip32(longint'(body_w[i]) + ((sum / 6) >>> 8));
        end
        body_w = s;
      end
    end
    res.rate = body_w;
    res.sat  = clipped;
    res.sing = sing;
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid) rate_expect.push_back(advance_rate(cur_req));
      if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = req_q.pop_front();
        item_valid  <= 1'b1;
        cmd         <= cur_req.cmd;
        step_len    <= cur_req.step;
        wheel_mom_x <= cur_req.mom[0];
        wheel_mom_y <= cur_req.mom[1];
        wheel_mom_z <= cur_req.mom[2];
        torque_x    <= cur_req.trq[0];
        torque_y    <= cur_req.trq[1];
        torque_z    <= cur_req.trq[2];
        load_rate_x <= cur_req.ld[0];
        load_rate_y <= cur_req.ld[1];
        load_rate_z <= cur_req.ld[2];
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rate_res_t e;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
      if (result_valid && !result_stall) begin
        if (rate_expect.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %0d %0d %0d", rate_x, rate_y, rate_z);
        end else begin
          e = rate_expect.pop_front();
          if (rate_x !== e.rate[0] || rate_y !== e.rate[1] || rate_z !== e.rate[2] ||
              saturated !== e.sat || singular !== e.sing) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %0d %0d %0d sat %0d sing %0d, got %0d %0d %0d sat %0d sing %0d",
                       e.rate[0], e.rate[1], e.rate[2], e.sat, e.sing,
                       rate_x, rate_y, rate_z, saturated, singular);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random value with magnitude below 2^bits
  function automatic int rnd_bits(input int bits);
    int v;
    v = $urandom;
    return v >>> (32 - bits);
  endfunction

  function automatic rate_req_t rand_req();
    rate_req_t r;
    bit wild;
    wild = ($urandom_range(99) < 15);
    r.cmd  = ($urandom_range(99) < 15) ? CMD_LOAD : CMD_STEP;
    r.step = wild ? $urandom : ($urandom >> $urandom_range(6, 12));
    for (int i = 0; i < 3; i++) begin
      r.mom[i] = wild ? int'($urandom) : rnd_bits(20);
      r.trq[i] = wild ? int'($urandom) : rnd_bits(18);
      r.ld[i]  = wild ? int'($urandom) : rnd_bits(25);
    end
    return r;
  endfunction

  function automatic rate_req_t mk_req(input bit c, input bit [31:0] st, input int mv,
                                       input int tv, input int lv);
    rate_req_t r;
    r.cmd = c;
    r.step = st;
    for (int i = 0; i < 3; i++) begin
      r.mom[i] = mv;
      r.trq[i] = tv;
      r.ld[i]  = (i == 1) ? -lv : lv;
    end
    return r;
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (req_q.size() != 0 || item_valid || rate_expect.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input ent_t idx, input bit [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= E_YZ) begin
      jmat[idx] = (idx <= E_ZZ) ? longint'(d[30:0]) : longint'(signed'(d));
      inv_ready = 1'b0;
    end
  endtask

  task automatic load_inertia(input int kind);
    bit [31:0] v[6];
    case (kind)
      0: begin  // well-conditioned, mildly coupled
        for (int i = 0; i < 3; i++) v[i] = {1'($urandom), 31'($urandom_range(1 << 18, 1 << 22))};
        for (int i = 3; i < 6; i++) v[i] = rnd_bits(16);
      end
      1: v = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0};  // inverse clips
      2: v = '{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};  // singular
      3: v = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      default: for (int i = 0; i < 6; i++) v[i] = $urandom;
    endcase
    for (int i = 0; i < 6; i++) write_reg(ent_t'(i), v[i]);
    if (kind == 2) write_reg(IDX_UNUSED, $urandom);  // must not clear the inverse flag
    cfg_valid <= 1'b0;
  endtask

  initial begin
    jmat = '{64'd655360, 64'd1310720, 64'd1966080, 64'd0, 64'd0, 64'd0};
    inv_j = '{default: 0};
    inv_ready = 1'b0;
    body_w = '{838861, -671089, 1677722};
    send_idle_pct = 20;
    recv_stall_pct = 85;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed requests on the reset inertia
    req_q.push_back(mk_req(CMD_STEP, 32'h0100_0000, 0, 0, 0));
    req_q.push_back(mk_req(CMD_STEP, 32'd0, 12345, -6789, 0));
    req_q.push_back(mk_req(CMD_LOAD, 32'd0, 0, 0, 32'h7FFF_FFFF));
    req_q.push_back(mk_req(CMD_STEP, 32'h0080_0000, 0, 0, 0));
    req_q.push_back(mk_req(CMD_LOAD, 32'hFFFF_FFFF, -1, -1, 32'h8000_0000));
    req_q.push_back(mk_req(CMD_STEP, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    req_q.push_back(mk_req(CMD_LOAD, 32'd0, 0, 0, 0));
    req_q.push_back(mk_req(CMD_STEP, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
    req_q.push_back(mk_req(CMD_LOAD, 32'd0, 0, 0, 1 << 24));
    req_q.push_back(mk_req(CMD_STEP, 32'h1000_0000, 1 << 20, -(1 << 16), 0));
    req_q.push_back(mk_req(CMD_STEP, 32'h0000_0001, -(1 << 20), 1 << 16, 0));
    req_q.push_back(mk_req(CMD_LOAD, 32'd0, 0, 0, -1));
    req_q.push_back(mk_req(CMD_STEP, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0));
    req_q.push_back(mk_req(CMD_STEP, 32'h0400_0000, 32'h8000_0000, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 20 : (ph == 1) ? 85 : 0;
      recv_stall_pct = (ph == 0) ? 85 : (ph == 1) ? 20 : 0;
      for (int set = 0; set < 4; set++) begin
        load_inertia((set == 3) ? 3 + ph % 2 : (set == 0) ? 0 : (set + ph) % 3);
        for (int n = 0; n < SET_ITEMS; n++) req_q.push_back(rand_req());
        wait_idle();
      end
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
